### src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, operation codes, word types and the divider step.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int VAL_W      = 2 * DATA_WIDTH + 2;
    localparam int CMP_W      = 3 * DATA_WIDTH;
    localparam int DIV_STEPS  = DATA_WIDTH;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        t_op                           op;
        logic                          dbz;
        logic signed [DATA_WIDTH-1:0]  a_re;
        logic signed [DATA_WIDTH-1:0]  a_im;
        logic signed [DATA_WIDTH-1:0]  b_re;
        logic signed [DATA_WIDTH-1:0]  b_im;
    } t_item;

    typedef struct packed {
        logic                    neg;
        logic                    big;
        logic [PROD_W-1:0]       rem;
        logic [DATA_WIDTH-1:0]   quo;
        logic [DATA_WIDTH-1:0]   shf;
    } t_part;

    typedef struct packed {
        logic                    valid;
        t_op                     op;
        logic                    dbz;
        logic signed [VAL_W-1:0] v_re;
        logic signed [VAL_W-1:0] v_im;
        logic [PROD_W-1:0]       den;
        t_part                   p_re;
        t_part                   p_im;
    } t_dstage;

    function automatic t_part div_step(t_part p, logic [PROD_W-1:0] den);
        logic [PROD_W:0] r2;
        logic            ge;
        t_part           n;
        r2    = {p.rem, p.shf[DATA_WIDTH-1]};
        ge    = (r2 >= {1'b0, den});
        n     = p;
        n.rem = ge ? PROD_W'(r2 - {1'b0, den}) : r2[PROD_W-1:0];
        n.quo = {p.quo[DATA_WIDTH-2:0], ge};
        n.shf = {p.shf[DATA_WIDTH-2:0], 1'b0};
        return n;
    endfunction

endpackage

### src/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Command intake: registers one word and classifies it for the queue.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [1:0]                           i_func,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_im,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_im,
    input  logic                                 i_q_full,
    output logic                                 o_busy,
    output logic                                 o_push,
    output cau_pkg::t_item                       o_item
);
    import cau_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  accept;

    assign o_busy = r_valid & i_q_full;
    assign o_push = r_valid & ~i_q_full;
    assign o_item = r_item;
    assign accept = i_start & ~o_busy;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid     = 1'b1;
            n_item.op   = t_op'(i_func);
            n_item.dbz  = (t_op'(i_func) == OP_DIV) && (i_b_re == '0) && (i_b_im == '0);
            n_item.a_re = i_a_re;
            n_item.a_im = i_a_im;
            n_item.b_re = i_b_re;
            n_item.b_im = i_b_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

### src/cau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_queue
// Short word queue between intake and datapath.
// ----------------------------------------------------------------------------
module cau_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cau_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output cau_pkg::t_item o_item
);
    import cau_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wp  = i_push ? QPTR_W'(r_wp + 1'b1) : r_wp;
        n_rp  = do_pop ? QPTR_W'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = QCNT_W'(r_cnt + 1'b1);
        end else if (!i_push && do_pop) begin
            n_cnt = QCNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### src/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Datapath: products, combine, pipelined restoring divide, saturate.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_empty,
    input  cau_pkg::t_item                        i_item,
    output logic                                  o_pop,
    output logic                                  o_valid,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_re,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_im,
    output logic                                  o_overflow,
    output logic                                  o_divide_by_zero
);
    import cau_pkg::*;

    localparam logic signed [VAL_W-1:0] SAT_MAX = VAL_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [VAL_W-1:0] SAT_MIN = -VAL_W'(64'sd1 <<< (DATA_WIDTH - 1));
    localparam logic [VAL_W-1:0]        BIG_MAG = VAL_W'(64'd1 << DATA_WIDTH);

    // stage 1: products
    logic                          r1_valid;
    t_op                           r1_op;
    logic                          r1_dbz;
    logic signed [PROD_W-1:0]      r1_rr, r1_ii, r1_ri, r1_ir, r1_sr, r1_si;
    logic signed [DATA_WIDTH:0]    r1_s_re, r1_s_im;

    // stage 2: combine
    logic                          r2_valid;
    t_op                           r2_op;
    logic                          r2_dbz;
    logic signed [VAL_W-1:0]       r2_v_re, r2_v_im;
    logic [PROD_W-1:0]             r2_den;

    t_dstage                       r_dv [DIV_STEPS+1];
    t_dstage                       n_dv0;

    logic                          r_valid;
    logic signed [DATA_WIDTH-1:0]  r_res_re, r_res_im;
    logic                          r_ovf, r_dbz;

    logic signed [VAL_W-1:0]       n2_v_re, n2_v_im;
    logic signed [VAL_W-1:0]       f_re, f_im;
    logic signed [DATA_WIDTH-1:0]  s_re, s_im;
    logic                          ov_re, ov_im;

    assign o_pop = ~i_empty;

    function automatic t_part part_init(logic signed [VAL_W-1:0] v, logic [PROD_W-1:0] den);
        logic [VAL_W-1:0] mag;
        t_part            p;
        mag   = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
        p.neg = v[VAL_W-1];
        p.big = CMP_W'(mag) >= (CMP_W'(den) << (DATA_WIDTH - FRAC_BITS));
        p.rem = PROD_W'(mag >> (DATA_WIDTH - FRAC_BITS));
        p.shf = DATA_WIDTH'(mag << FRAC_BITS);
        p.quo = '0;
        return p;
    endfunction

    function automatic logic signed [VAL_W-1:0] part_val(t_part p);
        logic [VAL_W-1:0] mag;
        mag = p.big ? BIG_MAG : VAL_W'(p.quo);
        return p.neg ? -$signed(mag) : $signed(mag);
    endfunction

    always_comb begin
        case (r1_op)
            OP_MUL: begin
                n2_v_re = VAL_W'(r1_rr) - VAL_W'(r1_ii);
                n2_v_im = VAL_W'(r1_ri) + VAL_W'(r1_ir);
            end
            OP_DIV: begin
                n2_v_re = VAL_W'(r1_rr) + VAL_W'(r1_ii);
                n2_v_im = VAL_W'(r1_ir) - VAL_W'(r1_ri);
            end
            default: begin
                n2_v_re = VAL_W'(r1_s_re);
                n2_v_im = VAL_W'(r1_s_im);
            end
        endcase
    end

    always_comb begin
        n_dv0.valid = r2_valid;
        n_dv0.op    = r2_op;
        n_dv0.dbz   = r2_dbz;
        n_dv0.den   = r2_den;
        n_dv0.v_re  = (r2_op == OP_MUL) ? (r2_v_re >>> FRAC_BITS) : r2_v_re;
        n_dv0.v_im  = (r2_op == OP_MUL) ? (r2_v_im >>> FRAC_BITS) : r2_v_im;
        n_dv0.p_re  = part_init(r2_v_re, r2_den);
        n_dv0.p_im  = part_init(r2_v_im, r2_den);
    end

    always_comb begin
        f_re = (r_dv[DIV_STEPS].op == OP_DIV) ? part_val(r_dv[DIV_STEPS].p_re)
                                              : r_dv[DIV_STEPS].v_re;
        f_im = (r_dv[DIV_STEPS].op == OP_DIV) ? part_val(r_dv[DIV_STEPS].p_im)
                                              : r_dv[DIV_STEPS].v_im;
        ov_re = (f_re > SAT_MAX) || (f_re < SAT_MIN);
        ov_im = (f_im > SAT_MAX) || (f_im < SAT_MIN);
        s_re  = (f_re > SAT_MAX) ? DATA_WIDTH'(SAT_MAX) :
                (f_re < SAT_MIN) ? DATA_WIDTH'(SAT_MIN) : DATA_WIDTH'(f_re);
        s_im  = (f_im > SAT_MAX) ? DATA_WIDTH'(SAT_MAX) :
                (f_im < SAT_MIN) ? DATA_WIDTH'(SAT_MIN) : DATA_WIDTH'(f_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r1_valid <= o_pop;
            r2_valid <= r1_valid;
            r_valid  <= r_dv[DIV_STEPS].valid;
        end

        r1_op   <= i_item.op;
        r1_dbz  <= i_item.dbz;
        r1_rr   <= i_item.a_re * i_item.b_re;
        r1_ii   <= i_item.a_im * i_item.b_im;
        r1_ri   <= i_item.a_re * i_item.b_im;
        r1_ir   <= i_item.a_im * i_item.b_re;
        r1_sr   <= i_item.b_re * i_item.b_re;
        r1_si   <= i_item.b_im * i_item.b_im;
        r1_s_re <= (i_item.op == OP_SUB)
                   ? (DATA_WIDTH+1)'(i_item.a_re) - (DATA_WIDTH+1)'(i_item.b_re)
                   : (DATA_WIDTH+1)'(i_item.a_re) + (DATA_WIDTH+1)'(i_item.b_re);
        r1_s_im <= (i_item.op == OP_SUB)
                   ? (DATA_WIDTH+1)'(i_item.a_im) - (DATA_WIDTH+1)'(i_item.b_im)
                   : (DATA_WIDTH+1)'(i_item.a_im) + (DATA_WIDTH+1)'(i_item.b_im);

        r2_op   <= r1_op;
        r2_dbz  <= r1_dbz;
        r2_v_re <= n2_v_re;
        r2_v_im <= n2_v_im;
        r2_den  <= PROD_W'($unsigned(r1_sr) + $unsigned(r1_si));

        r_res_re <= r_dv[DIV_STEPS].dbz ? '0 : s_re;
        r_res_im <= r_dv[DIV_STEPS].dbz ? '0 : s_im;
        r_ovf    <= ~r_dv[DIV_STEPS].dbz & (ov_re | ov_im);
        r_dbz    <= r_dv[DIV_STEPS].dbz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].valid <= 1'b0;
        end else begin
            r_dv[0].valid <= n_dv0.valid;
        end
        r_dv[0].op   <= n_dv0.op;
        r_dv[0].dbz  <= n_dv0.dbz;
        r_dv[0].den  <= n_dv0.den;
        r_dv[0].v_re <= n_dv0.v_re;
        r_dv[0].v_im <= n_dv0.v_im;
        r_dv[0].p_re <= n_dv0.p_re;
        r_dv[0].p_im <= n_dv0.p_im;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k].valid <= 1'b0;
            end else begin
                r_dv[k].valid <= r_dv[k-1].valid;
            end
            r_dv[k].op   <= r_dv[k-1].op;
            r_dv[k].dbz  <= r_dv[k-1].dbz;
            r_dv[k].den  <= r_dv[k-1].den;
            r_dv[k].v_re <= r_dv[k-1].v_re;
            r_dv[k].v_im <= r_dv[k-1].v_im;
            r_dv[k].p_re <= div_step(r_dv[k-1].p_re, r_dv[k-1].den);
            r_dv[k].p_im <= div_step(r_dv[k-1].p_im, r_dv[k-1].den);
        end
    end

    assign o_valid          = r_valid;
    assign o_res_re         = r_res_re;
    assign o_res_im         = r_res_im;
    assign o_overflow       = r_ovf;
    assign o_divide_by_zero = r_dbz;

endmodule

### src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Path: from an accepted start to the o_valid strobe, every operation passes the same registers:
// intake, queue, products, combine, 17 divider stages and the output register, in that order.
// Throughput: one word per cycle; every stage is pipelined and the datapath never stalls.
// busy only rises if the intake queue fills, which a non-stalling datapath never lets happen.
// Reset: synchronous, active low; clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed Q8.8 with saturation.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_func,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_a_im,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_re,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] i_b_im,
    output logic                                  o_valid,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_re,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] o_res_im,
    output logic                                  o_overflow,
    output logic                                  o_divide_by_zero
);
    import cau_pkg::*;

    localparam int LATENCY = DIV_STEPS + 6;

    logic  q_full, q_empty, push, pop;
    t_item f_item, q_item;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .i_q_full(q_full),
        .o_busy  (busy),
        .o_push  (push),
        .o_item  (f_item)
    );

    cau_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (f_item),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_item (q_item)
    );

    cau_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_item          (q_item),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_res_re        (o_res_re),
        .o_res_im        (o_res_im),
        .o_overflow      (o_overflow),
        .o_divide_by_zero(o_divide_by_zero)
    );

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("result strobe missing after fixed latency");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("intake stalled on a non-stalling datapath");

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_res_re == '0 && o_res_im == '0 && !o_overflow))
        else $error("zero divisor result not cleared");

    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !q_empty || pop)
        else $error("pushed word lost from queue");

endmodule
